// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL folder.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- hdl/chlcd_pkg.sv -----
// ---------------------------------------------------------------------------
// Character LCD shadow refresh package
// Defaults, opcodes, walk states and the display row offset table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package chlcd_pkg;

   localparam int COLUMNS_DEF = 16;
   localparam int ROWS_DEF    = 4;

   localparam logic [2:0] LINE_COUNT_RESET = 3'd4;

   localparam logic [1:0] OP_WRITE    = 2'd0;
   localparam logic [1:0] OP_POSITION = 2'd1;
   localparam logic [1:0] OP_REFRESH  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_FLUSH
   } state_type;

   function automatic logic [6:0] row_base(input logic [1:0] row);
      logic [6:0] base;
      case (row)
         2'd0:    base = 7'h00;
         2'd1:    base = 7'h40;
         2'd2:    base = 7'h0F;
         default: base = 7'h4F;
      endcase
      return base;
   endfunction

endpackage

// ----- hdl/char_lcd_shadow_refresh.sv -----
// ---------------------------------------------------------------------------
// Character LCD shadow refresh
// Pending and shown character buffers with a write cursor; a refresh request
// walks all cells and emits display RAM writes for the cells that changed.
// ---------------------------------------------------------------------------
//  channel  direction  ports
//  req      in         req_valid/req_ready, opcode, char_value, column, row
//  rsp      out        rsp_valid/rsp_ready, ddram_address, char_data, last_of_run
//  csr      in         csr_valid/csr_ready, line_count
//
//  Write and position requests are applied when accepted and leave the block in ST_IDLE.
//  A refresh walks every cell in turn (memory read, then compare and write
//  back) and ends with a closing flush step; rsp stalls lengthen it.
//  A stalled rsp holds the walk at its current cell; req_ready stays low.
//  Reset clears cursor and per-entry valid bits and sets line count to 4; no clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module char_lcd_shadow_refresh #(
   parameter int COLUMNS = chlcd_pkg::COLUMNS_DEF,
   parameter int ROWS    = chlcd_pkg::ROWS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_opcode,
   input  logic [7:0] req_char_value,
   input  logic [4:0] req_column,
   input  logic [2:0] req_row,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [6:0] rsp_ddram_address,
   output logic [7:0] rsp_char_data,
   output logic       rsp_last_of_run,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_line_count
);

   import chlcd_pkg::*;

   localparam int CELLS = ROWS * COLUMNS;
   localparam int IW    = $clog2(CELLS);
   localparam int CW    = $clog2(COLUMNS);

   state_type state_ff, state_in;

   logic [2:0]    line_count_ff;
   logic [CW-1:0] cursor_col_ff;
   logic [1:0]    cursor_row_ff;
   logic [CW-1:0] walk_col_ff;
   logic [1:0]    walk_row_ff;
   logic [IW-1:0] walk_idx_ff;

   logic [7:0]       pend_mem [CELLS];
   logic [7:0]       shown_mem [CELLS];
   logic [CELLS-1:0] pend_vld_ff;
   logic [CELLS-1:0] shown_vld_ff;
   logic [7:0]       pend_rd_ff;
   logic [7:0]       shown_rd_ff;
   logic             pend_vld_rd_ff;
   logic             shown_vld_rd_ff;

   logic       hold_valid_ff;
   logic [6:0] hold_addr_ff;
   logic [7:0] hold_data_ff;

   logic       rsp_valid_ff;
   logic [6:0] rsp_addr_ff;
   logic [7:0] rsp_data_ff;
   logic       rsp_last_ff;

   logic          accept;
   logic          rd_en;
   logic          pend_we;
   logic          shown_we;
   logic          rsp_load;
   logic          rsp_last_in;
   logic          hold_take;
   logic          hold_clear;
   logic          walk_start;
   logic          walk_step;
   logic          can_push;
   logic          differ;
   logic          walk_stall;
   logic [7:0]    pend_cur;
   logic [7:0]    shown_cur;
   logic [IW-1:0] cursor_idx;
   logic [IW-1:0] walk_idx_calc;
   logic [2:0]    lines;
   logic [2:0]    disp_row;
   logic [6:0]    cell_addr;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign can_push  = !rsp_valid_ff || rsp_ready;

   assign pend_cur  = pend_vld_rd_ff ? pend_rd_ff : 8'd0;
   assign shown_cur = shown_vld_rd_ff ? shown_rd_ff : 8'd0;
   assign differ    = (pend_cur != shown_cur);

   assign walk_stall = (state_ff == ST_CHECK) && differ && hold_valid_ff && !can_push;

   assign cursor_idx = IW'(IW'(cursor_row_ff) * IW'(COLUMNS) + IW'(cursor_col_ff));
   assign walk_idx_calc = IW'(IW'(walk_row_ff) * IW'(COLUMNS) + IW'(walk_col_ff));

   // clamp the walk row below line_count, zero acting as one
   always_comb begin
      lines    = (line_count_ff == 3'd0) ? 3'd1 : line_count_ff;
      disp_row = {1'b0, walk_row_ff};
      if (disp_row >= lines) begin
         disp_row = lines - 3'd1;
      end
   end

   assign cell_addr = 7'(7'(walk_col_ff) + row_base(disp_row[1:0]));

   always_comb begin
      state_in    = state_ff;
      rd_en       = 1'b0;
      pend_we     = 1'b0;
      shown_we    = 1'b0;
      rsp_load    = 1'b0;
      rsp_last_in = 1'b0;
      hold_take   = 1'b0;
      hold_clear  = 1'b0;
      walk_start  = 1'b0;
      walk_step   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_opcode == OP_WRITE) begin
                  pend_we = 1'b1;
               end
               if (req_opcode == OP_REFRESH) begin
                  walk_start = 1'b1;
                  state_in   = ST_READ;
               end
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!walk_stall) begin
               if (differ) begin
                  shown_we  = 1'b1;
                  hold_take = 1'b1;
                  rsp_load  = hold_valid_ff;
               end
               if (walk_idx_ff == IW'(CELLS - 1)) begin
                  state_in = ST_FLUSH;
               end else begin
                  walk_step = 1'b1;
                  state_in  = ST_READ;
               end
            end
         end
         ST_FLUSH: begin
            if (!hold_valid_ff) begin
               state_in = ST_IDLE;
            end else if (can_push) begin
               rsp_load    = 1'b1;
               rsp_last_in = 1'b1;
               hold_clear  = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_we) begin
         pend_mem[cursor_idx] <= req_char_value;
      end
      if (rd_en) begin
         pend_rd_ff <= pend_mem[walk_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (shown_we) begin
         shown_mem[walk_idx_ff] <= pend_cur;
      end
      if (rd_en) begin
         shown_rd_ff <= shown_mem[walk_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_vld_ff     <= '0;
         shown_vld_ff    <= '0;
         pend_vld_rd_ff  <= 1'b0;
         shown_vld_rd_ff <= 1'b0;
      end else begin
         if (pend_we) begin
            pend_vld_ff[cursor_idx] <= 1'b1;
         end
         if (shown_we) begin
            shown_vld_ff[walk_idx_ff] <= 1'b1;
         end
         if (rd_en) begin
            pend_vld_rd_ff  <= pend_vld_ff[walk_idx_ff];
            shown_vld_rd_ff <= shown_vld_ff[walk_idx_ff];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_count_ff <= LINE_COUNT_RESET;
         cursor_col_ff <= '0;
         cursor_row_ff <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            line_count_ff <= csr_line_count;
         end
         if (accept) begin
            unique case (req_opcode)
               OP_WRITE: begin
                  if (cursor_col_ff == CW'(COLUMNS - 1)) begin
                     cursor_col_ff <= '0;
                  end else begin
                     cursor_col_ff <= cursor_col_ff + CW'(1);
                  end
               end
               OP_POSITION: begin
                  if (int'(req_column) < COLUMNS && int'(req_row) < ROWS) begin
                     cursor_col_ff <= CW'(req_column);
                     cursor_row_ff <= req_row[1:0];
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   // advance the walk counters in row-major order
   always_ff @(posedge clock) begin
      if (reset) begin
         walk_col_ff <= '0;
         walk_row_ff <= '0;
         walk_idx_ff <= '0;
      end else if (walk_start) begin
         walk_col_ff <= '0;
         walk_row_ff <= '0;
         walk_idx_ff <= '0;
      end else if (walk_step) begin
         walk_idx_ff <= walk_idx_ff + IW'(1);
         if (walk_col_ff == CW'(COLUMNS - 1)) begin
            walk_col_ff <= '0;
            walk_row_ff <= walk_row_ff + 2'd1;
         end else begin
            walk_col_ff <= walk_col_ff + CW'(1);
         end
      end
   end

   // hold the latest changed cell until the next one shows whether it is last
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else if (hold_take) begin
         hold_valid_ff <= 1'b1;
      end else if (hold_clear || walk_start) begin
         hold_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (hold_take) begin
         hold_addr_ff <= cell_addr;
         hold_data_ff <= pend_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_addr_ff <= hold_addr_ff;
         rsp_data_ff <= hold_data_ff;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ddram_address = rsp_addr_ff;
   assign rsp_char_data     = rsp_data_ff;
   assign rsp_last_of_run   = rsp_last_ff;

   `ASSERT_IMPLY(a_idle_hold_empty, clock, reset, state_ff == ST_IDLE, !hold_valid_ff)
   `ASSERT_NEXT(a_stall_hold, clock, reset, walk_stall, state_ff == ST_CHECK && $stable(walk_idx_ff))
   `ASSERT_IMPLY(a_walk_index, clock, reset, state_ff != ST_IDLE, walk_idx_ff == walk_idx_calc)

endmodule
